// ===== rtl/core/f2fx_pkg.sv =====
// ----------------------------------------------------------------------------
// Float to fixed converter package
// Shared constants and register indexes for the converter.
// ----------------------------------------------------------------------------
package f2fx_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned FracW = 5;
  localparam int unsigned IdxW  = 2;

  localparam logic [IdxW-1:0] RegFracBits = 2'd0;
  localparam logic [IdxW-1:0] RegIntMax   = 2'd1;
  localparam logic [IdxW-1:0] RegIntMin   = 2'd2;

  localparam logic [FracW-1:0] FracBitsRst = 5'd27;
  localparam logic [WordW-1:0] IntMaxRst   = 32'sd15;
  localparam logic [WordW-1:0] IntMinRst   = -32'sd16;

endpackage

// ===== rtl/core/f2fx_datapath.sv =====
// ----------------------------------------------------------------------------
// Float to fixed datapath
// Exponent decode, integer and fraction split, clamp and word assembly.
// ----------------------------------------------------------------------------
module f2fx_datapath (
  input  logic [31:0] value_bits_i,
  input  logic [4:0]  frac_bits_i,
  input  logic [31:0] int_max_i,
  input  logic [31:0] int_min_i,
  output logic [31:0] fixed_word_o
);

  logic        neg;
  logic [7:0]  expo;
  logic [23:0] mant;
  logic        sat;
  logic [31:0] mag;
  logic [55:0] frac_al;
  logic [31:0] fbits;
  logic [8:0]  sh;
  logic [33:0] ipart;
  logic [33:0] imax;
  logic [33:0] imin;
  logic [33:0] iclamp;

  always_comb begin
    neg  = value_bits_i[31];
    expo = value_bits_i[30:23];
    mant = (expo == 8'd0) ? {1'b0, value_bits_i[22:0]} : {1'b1, value_bits_i[22:0]};
    sh   = (expo == 8'd0) ? 9'd149 : (9'd150 - {1'b0, expo});
    sat  = 1'b0;
    mag  = '0;
    fbits = '0;
    frac_al = '0;
    if (expo == 8'hFF) begin
      sat = 1'b1;
    end else if (expo >= 8'd158) begin
      // Magnitude at least 2^31: all such values saturate.
      sat = 1'b1;
    end else if (expo >= 8'd150) begin
      mag = {8'd0, mant} << (expo - 8'd150);
    end else begin
      // The top 24 bits hold the integer part and the low 32 bits the
      // fraction, truncated to 32 bits below the point.
      frac_al = {mant, 32'd0} >> sh;
      mag     = {8'd0, frac_al[55:32]};
      // Keeping the top frac_bits bits of that fraction truncates it exactly.
      fbits   = frac_al[31:0] >> (6'd32 - {1'b0, frac_bits_i});
    end
    ipart = sat ? (neg ? -34'sd2147483649 : 34'sd2147483648)
                : (neg ? -{2'b00, mag} : {2'b00, mag});
    imax = {{2{int_max_i[31]}}, int_max_i};
    imin = {{2{int_min_i[31]}}, int_min_i};
    iclamp = ($signed(ipart) > $signed(imax)) ? imax : ipart;
    if ($signed(iclamp) < $signed(imin)) iclamp = imin;
    fixed_word_o = (iclamp[31:0] << frac_bits_i) | fbits;
  end

endmodule

// ===== rtl/core/float_to_fixed_converter_top.sv =====
// ----------------------------------------------------------------------------
// Float to fixed converter top level
// Converts IEEE-754 single words to n.m fixed-point register words.
// ----------------------------------------------------------------------------
// Usage: drive value_bits_i and pulse start_i; a word is taken at every
// edge where start_i is high and busy_o is low. busy_o is always low, so
// one word can enter each cycle. The result appears on fixed_word_o in the
// next cycle with done_o high for exactly that cycle; the receiver cannot
// stall and must take it then. Throughput is one word per cycle, set by the
// single result register after the decode logic.
// Registers are written through cfg_we_i, cfg_idx_i and cfg_data_i while
// the block is idle: index 0 fraction bits, 1 upper clamp, 2 lower clamp.
// Writes to other indexes are ignored. Reset restores 27 fraction bits,
// clamps of 15 and -16, and clears the result strobe.
// ----------------------------------------------------------------------------
module float_to_fixed_converter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] value_bits_i,
  output logic        done_o,
  output logic [31:0] fixed_word_o,
  input  logic        cfg_we_i,
  input  logic [f2fx_pkg::IdxW-1:0] cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  logic [4:0]  frac_bits_q;
  logic [31:0] int_max_q;
  logic [31:0] int_min_q;
  logic [31:0] word_d;
  logic [31:0] word_q;
  logic        done_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_bits_q <= f2fx_pkg::FracBitsRst;
      int_max_q   <= f2fx_pkg::IntMaxRst;
      int_min_q   <= f2fx_pkg::IntMinRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == f2fx_pkg::RegFracBits) frac_bits_q <= cfg_data_i[4:0];
      if (cfg_idx_i == f2fx_pkg::RegIntMax)   int_max_q   <= cfg_data_i;
      if (cfg_idx_i == f2fx_pkg::RegIntMin)   int_min_q   <= cfg_data_i;
    end
  end

  f2fx_datapath u_dp (
    .value_bits_i (value_bits_i),
    .frac_bits_i  (frac_bits_q),
    .int_max_i    (int_max_q),
    .int_min_i    (int_min_q),
    .fixed_word_o (word_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) word_q <= word_d;
  end

  assign done_o       = done_q;
  assign fixed_word_o = word_q;

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> done_o) else $error("word lost");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i |=> !done_o) else $error("spurious word");
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o) else $error("busy raised");

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Float to fixed converter testbench
// Drives single-precision words through the converter under several register
// settings and checks every result word against a built-in predictor.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CycleLimit = 200000;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              start_i = 1'b0;
  logic                              busy_o;
  logic [f2fx_pkg::WordW-1:0]        value_bits_i = '0;
  logic                              done_o;
  logic [f2fx_pkg::WordW-1:0]        fixed_word_o;
  logic                              cfg_we_i = 1'b0;
  logic [f2fx_pkg::IdxW-1:0]         cfg_idx_i = '0;
  logic [f2fx_pkg::WordW-1:0]        cfg_data_i = '0;

  // Predictor copy of the registers.
  logic [f2fx_pkg::FracW-1:0]        frac_bits_q;
  logic signed [63:0]                int_max_q;
  logic signed [63:0]                int_min_q;

  logic [f2fx_pkg::WordW-1:0]        expected_words[$];
  int unsigned                       error_count = 0;
  int unsigned                       cycle_count = 0;
  int unsigned                       send_idle_pct = 0;

  typedef struct {
    logic [f2fx_pkg::WordW-1:0] value;
    logic                       known;
    logic [f2fx_pkg::WordW-1:0] word;
  } stim_row_t;

  float_to_fixed_converter_top uut (.*);

  always #1 clk_i = ~clk_i;

  function automatic logic [f2fx_pkg::WordW-1:0] convert_word(
      logic [f2fx_pkg::WordW-1:0] bits);
    logic                       neg;
    logic [7:0]                 expo;
    logic [63:0]                mant;
    logic [63:0]                mag;
    logic [63:0]                fbits;
    logic [63:0]                frac;
    logic signed [63:0]         ipart;
    int                         sh;
    logic [f2fx_pkg::WordW-1:0] iw;
    neg   = bits[31];
    expo  = bits[30:23];
    mant  = {41'd0, bits[22:0]};
    mag   = 64'd0;
    fbits = 64'd0;
    if (expo == 8'hFF) begin
      mag = 64'h1_0000_0000;
    end else begin
      if (expo == 8'd0) begin
        sh = 149;
      end else begin
        mant[23] = 1'b1;
        sh = 150 - int'(expo);
      end
      if (sh <= 0) begin
        mag = (-sh > 8) ? 64'h1_0000_0000 : (mant << (-sh));
        if (mag > 64'h1_0000_0000) mag = 64'h1_0000_0000;
      end else if (sh < 56) begin
        frac  = mant & ((64'd1 << sh) - 64'd1);
        mag   = mant >> sh;
        fbits = (frac << frac_bits_q) >> sh;
      end
    end
    ipart = neg ? -$signed(mag) : $signed(mag);
    if (ipart > int_max_q) ipart = int_max_q;
    if (ipart < int_min_q) ipart = int_min_q;
    iw = ipart[31:0];
    return (iw << frac_bits_q) | fbits[31:0];
  endfunction

  task automatic report_mismatch(string what, logic [f2fx_pkg::WordW-1:0] got,
                                 logic [f2fx_pkg::WordW-1:0] want);
    error_count++;
    $display("mismatch: %s got %h expected %h", what, got, want);
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (done_o) begin
      if (expected_words.size() == 0) report_mismatch("unexpected word", fixed_word_o, '0);
      else begin
        if (fixed_word_o !== expected_words[0])
          report_mismatch("fixed_word", fixed_word_o, expected_words[0]);
        void'(expected_words.pop_front());
      end
    end
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [f2fx_pkg::IdxW-1:0] idx,
                           logic [f2fx_pkg::WordW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      f2fx_pkg::RegFracBits: frac_bits_q = data[f2fx_pkg::FracW-1:0];
      f2fx_pkg::RegIntMax:   int_max_q = {{32{data[31]}}, data};
      f2fx_pkg::RegIntMin:   int_min_q = {{32{data[31]}}, data};
      default: ;
    endcase
  endtask

  task automatic drain();
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(logic [f2fx_pkg::WordW-1:0] bits, logic known,
                           logic [f2fx_pkg::WordW-1:0] want);
    while ($urandom_range(99) < send_idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i      <= 1'b1;
    value_bits_i <= bits;
    do @(posedge clk_i); while (busy_o);
    expected_words.push_back(convert_word(bits));
    if (known && convert_word(bits) !== want)
      report_mismatch("table entry", convert_word(bits), want);
    @(negedge clk_i);
  endtask

  function automatic logic [f2fx_pkg::WordW-1:0] random_float();
    logic [f2fx_pkg::WordW-1:0] v;
    v = $urandom;
    case ($urandom_range(5))
      0: v[30:23] = 8'hFF;
      1: v[30:23] = 8'h00;
      2, 3: v[30:23] = 8'd120 + 8'($urandom_range(40));
      default: ;
    endcase
    return v;
  endfunction

  stim_row_t directed_rows[] = '{
    '{32'h0000_0000, 1'b1, 32'h0000_0000},  // zero
    '{32'h8000_0000, 1'b1, 32'h0000_0000},  // negative zero
    '{32'h3F80_0000, 1'b1, 32'h0800_0000},  // one
    '{32'h3F00_0000, 1'b1, 32'h0400_0000},  // one half
    '{32'h7F80_0000, 1'b1, 32'h7800_0000},  // positive infinity
    '{32'hFF80_0000, 1'b1, 32'h8000_0000},  // negative infinity
    '{32'h7FC0_0000, 1'b1, 32'h7800_0000},  // NaN, positive sign
    '{32'hFFFF_FFFF, 1'b1, 32'h8000_0000},  // NaN, negative sign
    '{32'h0000_0001, 1'b0, 32'h0},          // smallest subnormal
    '{32'h807F_FFFF, 1'b0, 32'h0},          // largest negative subnormal
    '{32'h4F00_0000, 1'b0, 32'h0},          // exactly 2^31
    '{32'hCF00_0000, 1'b0, 32'h0},
    '{32'h7F7F_FFFF, 1'b0, 32'h0},          // largest finite
    '{32'hBFC0_0000, 1'b0, 32'h0},          // minus one and a half
    '{32'h4170_0000, 1'b0, 32'h0},          // fifteen
    '{32'hC180_0000, 1'b0, 32'h0},          // minus sixteen
    '{32'h3FFF_FFFF, 1'b0, 32'h0}
  };

  initial begin
    frac_bits_q = f2fx_pkg::FracBitsRst;
    int_max_q   = 64'sd15;
    int_min_q   = -64'sd16;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      send_word(directed_rows[i].value, directed_rows[i].known, directed_rows[i].word);
    start_i <= 1'b0;
    drain();

    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: begin write_reg(f2fx_pkg::RegFracBits, 0);
                 write_reg(f2fx_pkg::RegIntMax, 32'h7FFF_FFFF);
                 write_reg(f2fx_pkg::RegIntMin, 32'h8000_0000); end
        1: begin write_reg(f2fx_pkg::RegFracBits, 31);
                 write_reg(f2fx_pkg::RegIntMax, 0);
                 write_reg(f2fx_pkg::RegIntMin, 32'hFFFF_FFFF); end
        2: begin write_reg(f2fx_pkg::RegFracBits, 16);
                 write_reg(f2fx_pkg::RegIntMax, 32'h8000_0000);
                 write_reg(f2fx_pkg::RegIntMin, 32'h7FFF_FFFF); end  // crossed bounds
        3: write_reg(2'd3, $urandom);  // unused index, ignored
        default: begin
          write_reg(f2fx_pkg::RegFracBits, $urandom);
          write_reg(f2fx_pkg::RegIntMax,
                    $urandom_range(2) == 0 ? $urandom : $urandom_range(70000));
          write_reg(f2fx_pkg::RegIntMin,
                    $urandom_range(2) == 0 ? $urandom : -$urandom_range(70000));
        end
      endcase
      send_idle_pct = (phase < 3) ? 16 : (phase < 6) ? 49 : 0;
      for (int n = 0; n < 50; n++) begin
        if (phase == 4 && n == 25) begin
          start_i <= 1'b0;
          drain();
        end
        send_word(random_float(), 1'b0, '0);
      end
      start_i <= 1'b0;
      drain();
    end

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
